@@ hw/rtl/tsm_pkg.sv @@
`default_nettype none
package tsm_pkg;

   localparam int unsigned HalfPeriodW = 16;
   localparam logic [HalfPeriodW-1:0] HALF_PERIOD_RESET = 16'd10;

   // command codes on the request channel
   typedef enum logic [1:0] {
      CMD_MEAS_TEMP  = 2'd0,
      CMD_MEAS_HUMID = 2'd1,
      CMD_SOFT_RESET = 2'd2,
      CMD_CONN_RESET = 2'd3
   } cmd_type;

   // bytes sent on the wire for the measure and soft reset commands
   localparam logic [7:0] BYTE_MEAS_TEMP  = 8'h03;
   localparam logic [7:0] BYTE_MEAS_HUMID = 8'h05;
   localparam logic [7:0] BYTE_SOFT_RESET = 8'h1e;

   // connection reset toggles sck while its bit index runs 0..8
   localparam logic [3:0] CONN_RESET_LAST_BIT = 4'd8;
   localparam logic [3:0] BYTE_LAST_BIT       = 4'd7;
   localparam logic [1:0] CHECKSUM_BYTE       = 2'd2;

   typedef enum logic [4:0] {
      PH_IDLE   = 5'd0,
      PH_CR_H   = 5'd1,
      PH_CR_L   = 5'd2,
      PH_ST0    = 5'd3,
      PH_ST1    = 5'd4,
      PH_ST2    = 5'd5,
      PH_ST3    = 5'd6,
      PH_ST4    = 5'd7,
      PH_ST5    = 5'd8,
      PH_WR_S   = 5'd9,
      PH_WR_H   = 5'd10,
      PH_WR_L   = 5'd11,
      PH_WR_ACK = 5'd12,
      PH_WAIT   = 5'd13,
      PH_RD_L   = 5'd14,
      PH_RD_H   = 5'd15,
      PH_RA_S   = 5'd16,
      PH_RA_H   = 5'd17,
      PH_RA_L   = 5'd18
   } phase_type;

   typedef struct packed {
      logic        sck;
      logic        sda_out;
      logic        sda_oe;
      logic        busy_res;
      logic        done_res;
      logic [15:0] value;
      logic [7:0]  checksum;
      logic        ack_error;
   } rsp_type;

endpackage
`default_nettype wire

@@ hw/rtl/tsm_intf.sv @@
`default_nettype none
interface tsm_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [1:0] command;
   logic       sda_in;

   modport source (output valid, output start_req, output command, output sda_in,
                   input ready);
   modport sink (input valid, input start_req, input command, input sda_in,
                 output ready);
endinterface

interface tsm_rsp_if;
   logic        valid;
   logic        ready;
   logic        sck;
   logic        sda_out;
   logic        sda_oe;
   logic        busy_res;
   logic        done_res;
   logic [15:0] value;
   logic [7:0]  checksum;
   logic        ack_error;

   modport source (output valid, output sck, output sda_out, output sda_oe,
                   output busy_res, output done_res, output value, output checksum,
                   output ack_error, input ready);
   modport sink (input valid, input sck, input sda_out, input sda_oe,
                 input busy_res, input done_res, input value, input checksum,
                 input ack_error, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tsm_seq.sv @@
`default_nettype none
module tsm_seq import tsm_pkg::*; #(
   parameter int unsigned TICK_COUNT_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire logic                   start_req,
   input  wire logic [1:0]             command,
   input  wire logic                   sda_in,
   input  wire logic [HalfPeriodW-1:0] half_period,
   output      rsp_type                rsp_data
);

   localparam int unsigned LimW = (TICK_COUNT_WIDTH > HalfPeriodW) ?
                                  TICK_COUNT_WIDTH : HalfPeriodW;
   localparam logic [LimW-1:0] CountMax = LimW'((64'd1 << TICK_COUNT_WIDTH) - 64'd1);

   phase_type                   phase_ff, phase_in;
   logic [TICK_COUNT_WIDTH-1:0] tick_ff, tick_in, tick_inc, limit;
   logic [3:0]                  bit_ff, bit_in;
   logic [1:0]                  byte_ff, byte_in;
   logic [7:0]                  shift_ff, shift_in, shift_rd;
   cmd_type                     cmd_ff, cmd_in;
   logic [15:0]                 value_ff, value_in;
   logic [7:0]                  chk_ff, chk_in;
   logic                        ackerr_ff, ackerr_in;
   logic                        done;
   logic [LimW-1:0]             half_ext;
   logic [7:0]                  cmd_byte;

   // zero period acts as one, an oversized period saturates the counter
   always_comb begin
      half_ext = LimW'(half_period);
      if (half_period == '0) begin
         half_ext = LimW'(1);
      end
      if (half_ext > CountMax) begin
         half_ext = CountMax;
      end
      limit = half_ext[TICK_COUNT_WIDTH-1:0];
   end

   always_comb begin
      case (cmd_ff)
         CMD_MEAS_TEMP:  cmd_byte = BYTE_MEAS_TEMP;
         CMD_MEAS_HUMID: cmd_byte = BYTE_MEAS_HUMID;
         default:        cmd_byte = BYTE_SOFT_RESET;
      endcase
   end

   assign tick_inc = tick_ff + 1'b1;
   assign shift_rd = {shift_ff[6:0], sda_in};

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      shift_in  = shift_ff;
      cmd_in    = cmd_ff;
      value_in  = value_ff;
      chk_in    = chk_ff;
      ackerr_in = ackerr_ff;
      done      = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (start_req) begin
            cmd_in    = cmd_type'(command);
            ackerr_in = 1'b0;
            bit_in    = '0;
            byte_in   = '0;
            shift_in  = '0;
            tick_in   = '0;
            if (command == CMD_MEAS_TEMP || command == CMD_MEAS_HUMID) begin
               phase_in = PH_ST0;
            end else begin
               phase_in = PH_CR_H;
            end
         end
      end else if (phase_ff == PH_WAIT) begin
         if (!sda_in) begin
            bit_in   = '0;
            byte_in  = '0;
            shift_in = '0;
            tick_in  = '0;
            phase_in = PH_RD_L;
         end
      end else begin
         tick_in = tick_inc;
         if (tick_inc >= limit) begin
            tick_in = '0;
            case (phase_ff)
               PH_CR_H: phase_in = PH_CR_L;
               PH_CR_L: begin
                  if (bit_ff >= CONN_RESET_LAST_BIT) begin
                     bit_in   = '0;
                     phase_in = PH_ST0;
                  end else begin
                     bit_in   = bit_ff + 1'b1;
                     phase_in = PH_CR_H;
                  end
               end
               PH_ST0: phase_in = PH_ST1;
               PH_ST1: phase_in = PH_ST2;
               PH_ST2: phase_in = PH_ST3;
               PH_ST3: phase_in = PH_ST4;
               PH_ST4: phase_in = PH_ST5;
               PH_ST5: begin
                  if (cmd_ff == CMD_CONN_RESET) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     shift_in = cmd_byte;
                     bit_in   = '0;
                     phase_in = PH_WR_S;
                  end
               end
               PH_WR_S: phase_in = PH_WR_H;
               PH_WR_H: phase_in = PH_WR_L;
               PH_WR_L: begin
                  if (bit_ff >= BYTE_LAST_BIT) begin
                     phase_in = PH_WR_ACK;
                  end else begin
                     bit_in   = bit_ff + 1'b1;
                     phase_in = PH_WR_S;
                  end
               end
               PH_WR_ACK: begin
                  ackerr_in = sda_in;
                  if (cmd_ff == CMD_SOFT_RESET) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
               PH_RD_L: phase_in = PH_RD_H;
               PH_RD_H: begin
                  shift_in = shift_rd;
                  if (bit_ff >= BYTE_LAST_BIT) begin
                     if (byte_ff == 2'd0) begin
                        value_in = {shift_rd, value_ff[7:0]};
                     end else if (byte_ff == 2'd1) begin
                        value_in = {value_ff[15:8], shift_rd};
                     end else begin
                        chk_in = shift_rd;
                     end
                     phase_in = PH_RA_S;
                  end else begin
                     bit_in   = bit_ff + 1'b1;
                     phase_in = PH_RD_L;
                  end
               end
               PH_RA_S: phase_in = PH_RA_H;
               PH_RA_H: phase_in = PH_RA_L;
               PH_RA_L: begin
                  if (byte_ff >= CHECKSUM_BYTE) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     byte_in  = byte_ff + 1'b1;
                     bit_in   = '0;
                     shift_in = '0;
                     phase_in = PH_RD_L;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // line levels follow the updated phase
   always_comb begin
      rsp_data.sck       = 1'b0;
      rsp_data.sda_out   = 1'b1;
      rsp_data.sda_oe    = 1'b0;
      rsp_data.busy_res  = (phase_in != PH_IDLE);
      rsp_data.done_res  = done;
      rsp_data.value     = value_in;
      rsp_data.checksum  = chk_in;
      rsp_data.ack_error = ackerr_in;
      case (phase_in)
         PH_CR_H, PH_ST1, PH_ST5: begin
            rsp_data.sck    = 1'b1;
            rsp_data.sda_oe = 1'b1;
         end
         PH_CR_L, PH_ST0: rsp_data.sda_oe = 1'b1;
         PH_ST2, PH_ST4: begin
            rsp_data.sck     = 1'b1;
            rsp_data.sda_out = 1'b0;
            rsp_data.sda_oe  = 1'b1;
         end
         PH_ST3: begin
            rsp_data.sda_out = 1'b0;
            rsp_data.sda_oe  = 1'b1;
         end
         PH_WR_S, PH_WR_H, PH_WR_L: begin
            rsp_data.sda_out = shift_in[3'd7 - bit_in[2:0]];
            rsp_data.sda_oe  = 1'b1;
            rsp_data.sck     = (phase_in == PH_WR_H);
         end
         PH_WR_ACK, PH_RD_H: rsp_data.sck = 1'b1;
         PH_RA_S, PH_RA_H, PH_RA_L: begin
            // ack data bytes, leave the checksum byte unacknowledged
            rsp_data.sda_out = (byte_in >= CHECKSUM_BYTE);
            rsp_data.sda_oe  = 1'b1;
            rsp_data.sck     = (phase_in == PH_RA_H);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= '0;
         bit_ff    <= '0;
         byte_ff   <= '0;
         shift_ff  <= '0;
         cmd_ff    <= CMD_MEAS_TEMP;
         value_ff  <= '0;
         chk_ff    <= '0;
         ackerr_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         shift_ff  <= shift_in;
         cmd_ff    <= cmd_in;
         value_ff  <= value_in;
         chk_ff    <= chk_in;
         ackerr_ff <= ackerr_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/tsm_skid.sv @@
`default_nettype none
module tsm_skid import tsm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output      logic    in_ready,
   input  wire rsp_type in_data,
   output      logic    out_valid,
   input  wire logic    out_ready,
   output      rsp_type out_data
);

   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_data_ff, skid_data_ff;
   logic    out_load;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_load  = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_load) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (in_valid) begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_load) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_load) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (in_valid) begin
         if (out_load) begin
            out_data_ff <= in_data;
         end else begin
            skid_data_ff <= in_data;
         end
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/two_wire_sensor_measure_master.sv @@
// bit-level master for a two-wire humidity/temperature sensor. every request item is one
// tick of the line timebase carrying an optional start with a command and the sampled data
// line; every item gives exactly one response item with the line levels (sck, sda_out,
// sda_oe), busy and done flags, and the last raw value, checksum and ack error. one item is
// taken each clock cycle while the skid entry is empty: the tick is worked out by the
// sequencer's combinational step in the same cycle it is accepted, and its response is
// registered in a two-entry output buffer that lets one more item be taken while the
// response side stalls. the half period register (csr port, reset 10) sets ticks per
// clock half period and per settle delay; write it only while no command is running.
`default_nettype none
module two_wire_sensor_measure_master import tsm_pkg::*; #(
   parameter int unsigned TICK_COUNT_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   tsm_req_if.sink                     req_chan,
   tsm_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [HalfPeriodW-1:0] csr_wdata
);

   // half period register
   logic [HalfPeriodW-1:0] half_period_ff;

   logic    req_fire;
   logic    req_ready;
   rsp_type step_rsp;
   rsp_type out_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_we) begin
         half_period_ff <= csr_wdata;
      end
   end

   // state advances only on an accepted tick
   assign req_fire       = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   tsm_seq #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step_en     (req_fire),
      .start_req   (req_chan.start_req),
      .command     (req_chan.command),
      .sda_in      (req_chan.sda_in),
      .half_period (half_period_ff),
      .rsp_data    (step_rsp)
   );

   // response register plus skid entry
   tsm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_fire),
      .in_ready  (req_ready),
      .in_data   (step_rsp),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_rsp)
   );

   assign rsp_chan.sck       = out_rsp.sck;
   assign rsp_chan.sda_out   = out_rsp.sda_out;
   assign rsp_chan.sda_oe    = out_rsp.sda_oe;
   assign rsp_chan.busy_res  = out_rsp.busy_res;
   assign rsp_chan.done_res  = out_rsp.done_res;
   assign rsp_chan.value     = out_rsp.value;
   assign rsp_chan.checksum  = out_rsp.checksum;
   assign rsp_chan.ack_error = out_rsp.ack_error;

endmodule
`default_nettype wire

@@ tb/sv/two_wire_sensor_measure_checker.sv @@
`timescale 1ns / 100ps
module two_wire_sensor_measure_checker import tsm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   tsm_req_if                          req_mon,
   tsm_rsp_if                          rsp_mon,
   input  wire logic                   csr_we,
   input  wire logic [HalfPeriodW-1:0] csr_wdata,
   output int unsigned                 errors,
   output logic                        seq_idle,
   output int unsigned                 outstanding
);

   // sequencer state as the predictor sees it
   phase_type        seq_phase;
   logic [15:0]      step_ticks;
   logic [3:0]       bit_idx;
   logic [1:0]       byte_idx;
   logic [7:0]       shift_byte;
   cmd_type          cur_cmd;
   logic [15:0]      meas_value;
   logic [7:0]       meas_crc;
   logic             ack_err;
   logic [15:0]      half_period;

   rsp_type          expected_lines[$];
   int unsigned      err_cnt;

   initial begin
      err_cnt     = 0;
      errors      = 0;
      seq_idle    = 1'b1;
      outstanding = 0;
   end

   function automatic void go(input phase_type p);
      seq_phase  = p;
      step_ticks = '0;
   endfunction

   function automatic logic [7:0] command_byte(input cmd_type c);
      case (c)
         CMD_MEAS_TEMP:  return BYTE_MEAS_TEMP;
         CMD_MEAS_HUMID: return BYTE_MEAS_HUMID;
         default:        return BYTE_SOFT_RESET;
      endcase
   endfunction

   // closes the current timed step, returns 1 when the whole sequence is over
   function automatic logic close_step(input logic sda);
      logic finished;
      finished = 1'b0;
      case (seq_phase)
         PH_CR_H: go(PH_CR_L);
         PH_CR_L: begin
            if (bit_idx >= CONN_RESET_LAST_BIT) begin
               bit_idx = '0;
               go(PH_ST0);
            end else begin
               bit_idx++;
               go(PH_CR_H);
            end
         end
         PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4: go(phase_type'(seq_phase + 1));
         PH_ST5: begin
            if (cur_cmd == CMD_CONN_RESET) begin
               go(PH_IDLE);
               finished = 1'b1;
            end else begin
               shift_byte = command_byte(cur_cmd);
               bit_idx    = '0;
               go(PH_WR_S);
            end
         end
         PH_WR_S: go(PH_WR_H);
         PH_WR_H: go(PH_WR_L);
         PH_WR_L: begin
            if (bit_idx >= BYTE_LAST_BIT) go(PH_WR_ACK);
            else begin
               bit_idx++;
               go(PH_WR_S);
            end
         end
         PH_WR_ACK: begin
            ack_err = sda;
            if (cur_cmd == CMD_SOFT_RESET) begin
               go(PH_IDLE);
               finished = 1'b1;
            end else go(PH_WAIT);
         end
         PH_RD_L: go(PH_RD_H);
         PH_RD_H: begin
            shift_byte = {shift_byte[6:0], sda};
            if (bit_idx >= BYTE_LAST_BIT) begin
               if (byte_idx == CHECKSUM_BYTE) meas_crc = shift_byte;
               else if (byte_idx == 2'd1) meas_value[7:0] = shift_byte;
               else meas_value[15:8] = shift_byte;
               go(PH_RA_S);
            end else begin
               bit_idx++;
               go(PH_RD_L);
            end
         end
         PH_RA_S: go(PH_RA_H);
         PH_RA_H: go(PH_RA_L);
         PH_RA_L: begin
            if (byte_idx >= CHECKSUM_BYTE) begin
               go(PH_IDLE);
               finished = 1'b1;
            end else begin
               byte_idx++;
               bit_idx    = '0;
               shift_byte = '0;
               go(PH_RD_L);
            end
         end
         default: go(PH_IDLE);
      endcase
      return finished;
   endfunction

   // one timebase tick: advance the sequencer, then report the line levels
   function automatic rsp_type predict_tick(input logic start, input cmd_type cmd,
                                            input logic sda);
      rsp_type     r;
      logic        finished;
      logic [15:0] limit;
      finished = 1'b0;
      limit    = (half_period == '0) ? 16'd1 : half_period;
      if (seq_phase == PH_IDLE) begin
         if (start) begin
            cur_cmd    = cmd;
            ack_err    = 1'b0;
            bit_idx    = '0;
            byte_idx   = '0;
            shift_byte = '0;
            if (cmd == CMD_SOFT_RESET || cmd == CMD_CONN_RESET) go(PH_CR_H);
            else go(PH_ST0);
         end
      end else if (seq_phase == PH_WAIT) begin
         if (!sda) begin
            bit_idx    = '0;
            byte_idx   = '0;
            shift_byte = '0;
            go(PH_RD_L);
         end
      end else begin
         step_ticks = step_ticks + 16'd1;
         if (step_ticks >= limit) finished = close_step(sda);
      end

      r.sck     = 1'b0;
      r.sda_out = 1'b1;
      r.sda_oe  = 1'b0;
      case (seq_phase)
         PH_CR_H, PH_ST1, PH_ST5: begin
            r.sck    = 1'b1;
            r.sda_oe = 1'b1;
         end
         PH_CR_L, PH_ST0: r.sda_oe = 1'b1;
         PH_ST2, PH_ST4: begin
            r.sck     = 1'b1;
            r.sda_out = 1'b0;
            r.sda_oe  = 1'b1;
         end
         PH_ST3: begin
            r.sda_out = 1'b0;
            r.sda_oe  = 1'b1;
         end
         PH_WR_S, PH_WR_H, PH_WR_L: begin
            r.sda_out = shift_byte[3'(BYTE_LAST_BIT - bit_idx)];
            r.sda_oe  = 1'b1;
            r.sck     = (seq_phase == PH_WR_H);
         end
         PH_WR_ACK, PH_RD_H: r.sck = 1'b1;
         PH_RA_S, PH_RA_H, PH_RA_L: begin
            r.sda_out = (byte_idx >= CHECKSUM_BYTE);
            r.sda_oe  = 1'b1;
            r.sck     = (seq_phase == PH_RA_H);
         end
         default: ;
      endcase
      r.busy_res  = (seq_phase != PH_IDLE);
      r.done_res  = finished;
      r.value     = meas_value;
      r.checksum  = meas_crc;
      r.ack_error = ack_err;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         err_cnt++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         seq_phase   = PH_IDLE;
         step_ticks  = '0;
         bit_idx     = '0;
         byte_idx    = '0;
         shift_byte  = '0;
         cur_cmd     = CMD_MEAS_TEMP;
         meas_value  = '0;
         meas_crc    = '0;
         ack_err     = 1'b0;
         half_period = HALF_PERIOD_RESET;
         expected_lines.delete();
      end else begin
         if (csr_we) half_period = csr_wdata;
         // responses are registered after their tick, so pop before push
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_lines.size() == 0) begin
               $error("response item with no tick waiting");
               err_cnt++;
            end else begin
               want = expected_lines.pop_front();
               check_field("sck", 16'(want.sck), 16'(rsp_mon.sck));
               check_field("sda_out", 16'(want.sda_out), 16'(rsp_mon.sda_out));
               check_field("sda_oe", 16'(want.sda_oe), 16'(rsp_mon.sda_oe));
               check_field("busy_res", 16'(want.busy_res), 16'(rsp_mon.busy_res));
               check_field("done_res", 16'(want.done_res), 16'(rsp_mon.done_res));
               check_field("value", want.value, rsp_mon.value);
               check_field("checksum", 16'(want.checksum), 16'(rsp_mon.checksum));
               check_field("ack_error", 16'(want.ack_error), 16'(rsp_mon.ack_error));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_lines.push_back(predict_tick(req_mon.start_req,
                                                  cmd_type'(req_mon.command),
                                                  req_mon.sda_in));
      end
      errors      <= err_cnt;
      seq_idle    <= (seq_phase == PH_IDLE);
      outstanding <= expected_lines.size();
   end

endmodule

@@ tb/sv/two_wire_sensor_measure_master_tb.sv @@
`timescale 1ns / 100ps
module two_wire_sensor_measure_master_tb import tsm_pkg::*;;

   // cycles with no item moving on either channel before the run is declared hung
   localparam int unsigned QUIET_LIMIT   = 2000;
   // the response is registered in a two-entry buffer; wait this long after draining
   localparam int unsigned SETTLE_CYCLES = 6;

   typedef enum logic [1:0] {
      SDA_RANDOM,
      SDA_LOW,
      SDA_HIGH
   } sda_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [HalfPeriodW-1:0] csr_wdata;
   logic                   idle_on;

   int unsigned            errors;
   logic                   seq_idle;
   int unsigned            outstanding;

   tsm_req_if req_if();
   tsm_rsp_if rsp_if();

   two_wire_sensor_measure_master u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predicts every tick's line levels and checks the response stream
   two_wire_sensor_measure_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .errors      (errors),
      .seq_idle    (seq_idle),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // response side: when idling is on, a random stall before taking each item
   initial begin
      int unsigned stall;
      forever begin
         stall = idle_on ? $urandom_range(0, 3) : 0;
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // watchdog: ends the run when nothing has moved for too long
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   function automatic logic pick_sda(input sda_mode_type mode);
      case (mode)
         SDA_LOW:  return 1'b0;
         SDA_HIGH: return 1'b1;
         default:  return 1'($urandom_range(0, 1));
      endcase
   endfunction

   function automatic cmd_type any_cmd();
      return cmd_type'($urandom_range(0, 3));
   endfunction

   // one timebase tick; called at a rising edge, returns at the edge that takes it
   task automatic send_tick(input logic start, input cmd_type cmd, input logic sda);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.start_req <= start;
      req_if.command   <= cmd;
      req_if.sda_in    <= sda;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   // plain ticks until the sequencer is back to idle; the idle flag trails by one
   // item, which is harmless since a tick without start never leaves idle
   task automatic finish_sequence(input sda_mode_type mode);
      do send_tick(1'b0, any_cmd(), pick_sda(mode));
      while (!seq_idle);
   endtask

   // start a command, poke it with an ignored start while busy, then let it run out
   task automatic run_command(input cmd_type cmd, input sda_mode_type mode);
      send_tick(1'b1, cmd, pick_sda(mode));
      send_tick(1'b1, any_cmd(), pick_sda(mode));
      finish_sequence(mode);
   endtask

   // drain all responses, give the block time to settle, then write the period
   task automatic write_half_period(input logic [HalfPeriodW-1:0] ticks);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= ticks;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      req_if.valid     <= 1'b0;
      req_if.start_req <= 1'b0;
      req_if.command   <= CMD_MEAS_TEMP;
      req_if.sda_in    <= 1'b1;
      csr_we           <= 1'b0;
      csr_wdata        <= HALF_PERIOD_RESET;
      reset            <= 1'b1;
      idle_on          = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // idle ticks, then a connection reset at the reset period with data high
      send_tick(1'b0, CMD_MEAS_TEMP, 1'b0);
      send_tick(1'b0, CMD_CONN_RESET, 1'b1);
      run_command(CMD_CONN_RESET, SDA_HIGH);

      // fastest period: a measurement, then a soft reset left unacknowledged:
      // ack error set, value must survive it
      write_half_period(16'd1);
      run_command(CMD_MEAS_TEMP, SDA_RANDOM);
      run_command(CMD_SOFT_RESET, SDA_HIGH);

      // zero period behaves as one tick
      write_half_period(16'd0);
      run_command(CMD_MEAS_HUMID, SDA_RANDOM);

      // random ticks, first back to back, then with idling on both sides
      for (int p = 0; p < 2; p++) begin
         write_half_period(16'(p + 1));
         idle_on = (p != 0);
         repeat (30) send_tick($urandom_range(0, 3) == 0, any_cmd(), pick_sda(SDA_RANDOM));
         finish_sequence(SDA_RANDOM);
      end

      // longest period: just the opening of a measurement, never waited out
      idle_on = 1'b1;
      write_half_period(16'hffff);
      send_tick(1'b1, CMD_MEAS_TEMP, 1'b0);
      repeat (20) send_tick(1'($urandom_range(0, 1)), any_cmd(), pick_sda(SDA_RANDOM));

      // wait for the last responses, then give the verdict
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
